FILE: sv/clg_pkg.sv
// Shared types, character codes and arithmetic constants for the readability grader.
`default_nettype none
package clg_pkg;

   localparam int CNT_W   = 16;           // per-text counter width
   localparam int WORD_W  = CNT_W + 1;    // whitespace count plus one
   localparam int GRADE_W = 5;
   localparam int CLASS_W = 2;

   // Datapath widths of the index computation
   localparam int PA_W  = 26;             // 588 * letters
   localparam int PB_W  = 28;             // 2960 * sentences
   localparam int PC_W  = 27;             // 1580 * words
   localparam int DEN_W = 23;             // 100 * words
   localparam int NUM_W = 30;             // signed numerator
   localparam int REM_W = 29;             // partial remainder of the rounding divide
   localparam int QUO_W = 5;
   localparam int STEP_W = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [9:0]  COEF_LETTER   = 10'd588;
   localparam logic [11:0] COEF_SENTENCE = 12'd2960;
   localparam logic [10:0] COEF_WORD     = 11'd1580;
   localparam logic [6:0]  DEN_SCALE     = 7'd100;

   localparam logic [GRADE_W-1:0] GRADE_TOP = 5'd16;

   // Grade classes
   localparam logic [CLASS_W-1:0] CLASS_EXACT = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_BELOW = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_ABOVE = 2'd2;

   // Character codes
   localparam logic [7:0] CHR_TAB     = 8'h09;
   localparam logic [7:0] CHR_CR      = 8'h0D;
   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_BANG    = 8'h21;
   localparam logic [7:0] CHR_PERIOD  = 8'h2E;
   localparam logic [7:0] CHR_QUEST   = 8'h3F;
   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z = 8'h7A;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } clg_req_type;

   typedef struct packed {
      logic [GRADE_W-1:0] grade;
      logic [CLASS_W-1:0] grade_class;
      logic [CNT_W-1:0]   letter_total;
      logic [WORD_W-1:0]  word_total;
      logic [CNT_W-1:0]   sentence_total;
      logic               count_overflow;
   } clg_rsp_type;

   // One finished text's counts, handed from the counter front to the index unit
   typedef struct packed {
      logic [CNT_W-1:0]  letters;
      logic [CNT_W-1:0]  sentences;
      logic [WORD_W-1:0] words;
      logic              overflow;
   } clg_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } clg_qstat_type;

endpackage
`default_nettype wire

FILE: sv/clg_front.sv
// Byte classifier and saturating per-text counters; emits one job per finished text.
`default_nettype none
module clg_front
   import clg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  clg_req_type   req_data,
   input  clg_qstat_type q_stat,
   output logic          q_push,
   output clg_job_type   q_data
);

   logic [CNT_W-1:0] letter_ff, letter_in, letter_upd;
   logic [CNT_W-1:0] space_ff, space_in, space_upd;
   logic [CNT_W-1:0] sentence_ff, sentence_in, sentence_upd;
   logic             sat_ff, sat_in, sat_upd;
   logic             accept;
   logic             is_space, is_letter, is_sentence;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = accept && req_data.end_of_text;

   always_comb begin
      is_space    = 1'b0;
      is_letter   = 1'b0;
      is_sentence = 1'b0;
      case (req_data.text_byte) inside
         [CHR_TAB:CHR_CR], CHR_SPACE:                  is_space    = 1'b1;
         [CHR_UPPER_A:CHR_UPPER_Z], [CHR_LOWER_A:CHR_LOWER_Z]: is_letter = 1'b1;
         CHR_PERIOD, CHR_BANG, CHR_QUEST:              is_sentence = 1'b1;
         default:                                      ;
      endcase
   end

   always_comb begin
      letter_upd   = letter_ff;
      space_upd    = space_ff;
      sentence_upd = sentence_ff;
      sat_upd      = sat_ff;
      if (accept) begin
         if (is_space) begin
            if (space_ff == CNT_MAX) sat_upd = 1'b1;
            else                     space_upd = space_ff + 1'b1;
         end
         if (is_letter) begin
            if (letter_ff == CNT_MAX) sat_upd = 1'b1;
            else                      letter_upd = letter_ff + 1'b1;
         end
         if (is_sentence) begin
            if (sentence_ff == CNT_MAX) sat_upd = 1'b1;
            else                        sentence_upd = sentence_ff + 1'b1;
         end
      end
   end

   always_comb begin
      q_data.letters   = letter_upd;
      q_data.sentences = sentence_upd;
      q_data.words     = {1'b0, space_upd} + WORD_W'(1);
      q_data.overflow  = sat_upd;
   end

   // Clear counts once the text's job has gone to the queue
   assign letter_in   = q_push ? '0 : letter_upd;
   assign space_in    = q_push ? '0 : space_upd;
   assign sentence_in = q_push ? '0 : sentence_upd;
   assign sat_in      = q_push ? 1'b0 : sat_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_ff   <= '0;
         space_ff    <= '0;
         sentence_ff <= '0;
         sat_ff      <= 1'b0;
      end else begin
         letter_ff   <= letter_in;
         space_ff    <= space_in;
         sentence_ff <= sentence_in;
         sat_ff      <= sat_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/clg_queue.sv
// Two-entry job queue between the counter front and the index unit.
`default_nettype none
module clg_queue
   import clg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  clg_job_type   push_data,
   input  logic          pop,
   output clg_job_type   pop_data,
   output clg_qstat_type q_stat
);

   clg_job_type slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/clg_back.sv
// Index unit: scaled products, rounding restoring divide, classification, result register.
`default_nettype none
module clg_back
   import clg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  clg_qstat_type q_stat,
   output logic          q_pop,
   input  clg_job_type   q_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output clg_rsp_type   rsp_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PROD = 3'd1;
   localparam logic [2:0] ST_DIFF = 3'd2;
   localparam logic [2:0] ST_SAT  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]         state_ff, state_in;
   clg_job_type        job_ff, job_in;
   logic [PA_W-1:0]    pa_ff, pa_in;
   logic [PB_W-1:0]    pb_ff, pb_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic               neg_ff, neg_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [GRADE_W-1:0] grade_ff, grade_in;
   logic [CLASS_W-1:0] class_ff, class_in;
   logic               rsp_valid_ff, rsp_valid_in;
   clg_rsp_type        rsp_data_ff, rsp_data_in;

   logic signed [NUM_W-1:0] num;
   logic [REM_W-1:0]        rem_full;
   logic [REM_W-1:0]        div_shift;
   logic [REM_W-1:0]        sat_limit;
   logic                    load_rsp;

   assign q_pop     = (state_ff == ST_IDLE) && !q_stat.empty;
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign num = $signed(NUM_W'(pa_ff)) - $signed(NUM_W'(pb_ff)) - $signed(NUM_W'(pc_ff));
   assign rem_full  = REM_W'(unsigned'(num) << 1) + REM_W'(den_ff);
   assign div_shift = REM_W'(den_ff) << ({1'b0, step_ff} + 4'd1);
   assign sat_limit = REM_W'(den_ff) << 5;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      pc_in    = pc_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      grade_in = grade_ff;
      class_in = class_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               job_in   = q_data;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            pa_in    = PA_W'(job_ff.letters) * PA_W'(COEF_LETTER);
            pb_in    = PB_W'(job_ff.sentences) * PB_W'(COEF_SENTENCE);
            pc_in    = PC_W'(job_ff.words) * PC_W'(COEF_WORD);
            den_in   = DEN_W'(job_ff.words) * DEN_W'(DEN_SCALE);
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            neg_in   = num[NUM_W-1];
            rem_in   = rem_full;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            // Negative numerator rounds to zero or below; a quotient of 16+ saturates
            if (neg_ff) begin
               grade_in = '0;
               class_in = CLASS_BELOW;
               state_in = ST_DONE;
            end else if (rem_ff >= sat_limit) begin
               grade_in = GRADE_TOP;
               class_in = CLASS_ABOVE;
               state_in = ST_DONE;
            end else begin
               quo_in   = '0;
               step_in  = STEP_W'(QUO_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ff >= div_shift) begin
               rem_in          = rem_ff - div_shift;
               quo_in[step_ff] = 1'b1;
            end
            if (step_ff == '0) begin
               if (quo_in == '0) begin
                  grade_in = '0;
                  class_in = CLASS_BELOW;
               end else begin
                  grade_in = quo_in;
                  class_in = CLASS_EXACT;
               end
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_data_in.grade          = grade_ff;
      rsp_data_in.grade_class    = class_ff;
      rsp_data_in.letter_total   = job_ff.letters;
      rsp_data_in.word_total     = job_ff.words;
      rsp_data_in.sentence_total = job_ff.sentences;
      rsp_data_in.count_overflow = job_ff.overflow;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)              rsp_valid_in = 1'b1;
      else if (!rsp_stall)       rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      pc_ff    <= pc_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      grade_ff <= grade_in;
      class_ff <= class_in;
      if (load_rsp) rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/coleman_liau_grade_stream.sv
// Top level of the streaming Coleman-Liau readability grader.
//
//   channel | ports                               | moves
//   --------+-------------------------------------+-----------------------------------
//   input   | req_valid, req_stall, req_data      | one text byte and its last marker
//   result  | rsp_valid, rsp_stall, rsp_data      | grade, class, totals, overflow flag
//
// Flow: the front counts one byte per cycle unless req_stall holds it. Each finished
// text becomes one job in a two-entry queue; the index unit takes each job through a
// pop, product, difference, saturation check, five restoring-divide steps and a result
// load, or skips the divide when the numerator is negative or the index saturates at
// sixteen, so short texts run at the index unit's pace once the queue fills.
// Reset: synchronous, active high; clears counters, queue pointers, sequencer state
// and result valid. Stalls: req_stall rises only while the queue is full; a held
// result does not stop the index unit until it has its next result ready.
`default_nettype none
module coleman_liau_grade_stream
   import clg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  clg_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output clg_rsp_type rsp_data
);

   clg_qstat_type q_stat;
   logic          q_push;
   logic          q_pop;
   clg_job_type   q_push_data;
   clg_job_type   q_pop_data;

   // Front: classify each byte, bump saturating counts, push a job on the last byte
   clg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // Queue: decouple the byte stream from the multi-cycle index computation
   clg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .q_stat    (q_stat)
   );

   // Back: compute the rounded index, classify it and hold the result until taken
   clg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .q_data    (q_pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Never push into a full queue or pop an empty one
   assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full) && !(q_pop && q_stat.empty))
      else $error("job queue overrun or underrun");

   // An exact grade lies between one and fifteen; other classes pin the grade
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.grade_class == CLASS_EXACT && rsp_data.grade >= 5'd1 &&
                      rsp_data.grade <= 5'd15) ||
                     (rsp_data.grade_class == CLASS_BELOW && rsp_data.grade == '0) ||
                     (rsp_data.grade_class == CLASS_ABOVE && rsp_data.grade == GRADE_TOP)))
      else $error("grade and class disagree");

   // A result never carries a zero word count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.word_total != '0))
      else $error("result with zero words");

endmodule
`default_nettype wire
